[rtl/core/oa_lhs_pkg.sv]
// Package: shared types, constants and control structs for the OA-LHS stratum generator.
`default_nettype none
package oa_lhs_pkg;
	localparam int MaxDims  = 64;
	localparam int ModWidth = 16;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_PRIME = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_STEP  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_START = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_DIMS  = 2'd3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [5:0]  dim_index;
		logic [15:0] coef_a;
		logic [15:0] coef_b;
		logic [15:0] perm_mult;
		logic [15:0] perm_add;
	} in_item_t;

	typedef struct packed {
		logic [15:0] stratum;
		logic [5:0]  dim_out;
		logic        last;
	} out_item_t;

	// Sequencer to reduction unit.
	typedef struct packed {
		logic start;
		logic quot;
	} mod_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADV, ST_ADV_W, ST_SPLIT, ST_SPLIT_W,
		ST_RD, ST_M1, ST_R1, ST_R1_W, ST_M2, ST_R2, ST_R2_W, ST_OUT
	} state_t;
endpackage
`default_nettype wire

[rtl/core/oa_lhs_modred.sv]
// Shared iterative restoring reduction unit: x mod m and x / m, one bit per cycle.
`default_nettype none
module oa_lhs_modred #(
	parameter int ModWidth = oa_lhs_pkg::ModWidth
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  oa_lhs_pkg::mod_ctl_t       ctl,
	input  wire  [2*ModWidth+1:0]      x,
	input  wire  [2*ModWidth-1:0]      m,
	output logic                       busy,
	output logic [2*ModWidth+1:0]      quo,
	output logic [2*ModWidth-1:0]      rem
);
	localparam int XW = 2*ModWidth+2;
	localparam int MW = 2*ModWidth;
	localparam int CW = $clog2(XW+1);

	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] q_q;
	logic [MW:0]   r_q;
	logic [MW-1:0] m_q;
	logic [MW:0]   sh;
	logic [MW:0]   diff;

	assign sh   = {r_q[MW-1:0], x_q[XW-1]};
	assign diff = sh - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= CW'(XW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x;
			m_q <= m;
			r_q <= '0;
			q_q <= '0;
		end else if (cnt_q != '0) begin
			x_q <= {x_q[XW-2:0], 1'b0};
			if (!diff[MW]) begin
				r_q <= diff;
				q_q <= {q_q[XW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[XW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0) || ctl.start;
	assign quo  = (m_q == '0) ? '0 : q_q;
	assign rem  = (m_q == '0) ? '0 : r_q[MW-1:0];

`ifndef ASSERT_OFF
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && !ctl.start && m_q != '0) |-> (r_q[MW-1:0] < m_q))
		else $error("remainder not below modulus");
	a_cnt_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (cnt_q == CW'(XW)))
		else $error("count not loaded");
	a_quo_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.quot |-> ctl.start)
		else $error("quotient request without start");
`endif
endmodule
`default_nettype wire

[rtl/core/oa_lhs_stratum_generator_core.sv]
// Top level: OA-LHS stratum generator with coefficient table, sequencer and shared reduction.
// A load writes one table entry. A sample first advances the row and splits it into i and j,
// then per dimension reads the table, multiplies and runs two reductions, each result
// waiting in the output register until taken. The shared bit-serial reducer does every reduction.
// One item at a time; in_ready is low while a sample runs. Output held in a register.
// arst_n clears control, registers to their defaults and the row counter; tables stay unset.
`default_nettype none
module oa_lhs_stratum_generator_core #(
	parameter int MaxDims  = oa_lhs_pkg::MaxDims,
	parameter int ModWidth = oa_lhs_pkg::ModWidth
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  oa_lhs_pkg::in_item_t                  in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output oa_lhs_pkg::out_item_t                 out_data,
	input  wire                                   cfg_we,
	input  wire  [oa_lhs_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire  [oa_lhs_pkg::CfgDataW-1:0]       cfg_data
);
	localparam int AW = (MaxDims > 1) ? $clog2(MaxDims) : 1;
	localparam int MW = 2*ModWidth;
	localparam int XW = 2*ModWidth+2;

	oa_lhs_pkg::state_t state_q, state_d;

	logic [ModWidth-1:0] p_q;
	logic [31:0]         step_q;
	logic [31:0]         row_q;
	logic [MW-1:0]       total_q;
	logic [6:0]          dims_q;
	logic [ModWidth-1:0] i_q, j_q, s_q;
	logic [AW:0]         d_q;
	logic [AW:0]         n_lim;
	logic [MW-1:0]       prod_q;
	logic                in_acc, out_acc;

	logic [ModWidth-1:0] ta_mem [MaxDims];
	logic [ModWidth-1:0] tb_mem [MaxDims];
	logic [ModWidth-1:0] tm_mem [MaxDims];
	logic [ModWidth-1:0] td_mem [MaxDims];
	logic [ModWidth-1:0] ra_q, rb_q, rm_q, rd_q;

	oa_lhs_pkg::mod_ctl_t ctl;
	logic [XW-1:0]       mx;
	logic [MW-1:0]       mm;
	logic                mbusy;
	logic [XW-1:0]       mquo;
	logic [MW-1:0]       mrem;

	oa_lhs_modred #(.ModWidth(ModWidth)) u_red (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .x(mx), .m(mm),
		.busy(mbusy), .quo(mquo), .rem(mrem)
	);

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign n_lim   = (dims_q > 7'(MaxDims)) ? (AW+1)'(MaxDims) : (AW+1)'(dims_q);

	always_ff @(posedge clk) begin
		if (in_acc && in_data.op == oa_lhs_pkg::OP_LOAD && 32'(in_data.dim_index) < MaxDims) begin
			ta_mem[AW'(in_data.dim_index)] <= ModWidth'(in_data.coef_a);
			tb_mem[AW'(in_data.dim_index)] <= ModWidth'(in_data.coef_b);
			tm_mem[AW'(in_data.dim_index)] <= ModWidth'(in_data.perm_mult);
			td_mem[AW'(in_data.dim_index)] <= ModWidth'(in_data.perm_add);
		end
		if (state_q == oa_lhs_pkg::ST_RD) begin
			ra_q <= ta_mem[d_q[AW-1:0]];
			rb_q <= tb_mem[d_q[AW-1:0]];
			rm_q <= tm_mem[d_q[AW-1:0]];
			rd_q <= td_mem[d_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= ModWidth'(11);
			total_q <= MW'(121);
			step_q  <= 32'd1;
			row_q   <= '0;
			dims_q  <= 7'd1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					oa_lhs_pkg::REG_PRIME: begin
						p_q     <= ModWidth'(cfg_data);
						total_q <= MW'(ModWidth'(cfg_data)) * MW'(ModWidth'(cfg_data));
					end
					oa_lhs_pkg::REG_STEP:  step_q <= cfg_data;
					oa_lhs_pkg::REG_START: row_q  <= cfg_data;
					oa_lhs_pkg::REG_DIMS:  dims_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == oa_lhs_pkg::ST_ADV_W && !mbusy) begin
				row_q <= 32'(mrem);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			oa_lhs_pkg::ST_SPLIT_W: if (!mbusy) begin
				i_q <= ModWidth'(mquo);
				j_q <= ModWidth'(mrem);
			end
			oa_lhs_pkg::ST_M1: prod_q <= MW'(ra_q) * MW'(i_q);
			oa_lhs_pkg::ST_R1_W: if (!mbusy) s_q <= ModWidth'(mrem);
			oa_lhs_pkg::ST_M2: prod_q <= MW'(rm_q) * MW'(s_q);
			oa_lhs_pkg::ST_R2_W: if (!mbusy) s_q <= ModWidth'(mrem);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= oa_lhs_pkg::ST_IDLE;
			d_q       <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == oa_lhs_pkg::ST_SPLIT) d_q <= '0;
			if (state_q == oa_lhs_pkg::ST_OUT && out_acc) d_q <= d_q + 1'b1;
			if (state_q == oa_lhs_pkg::ST_R2_W && !mbusy) begin
				out_valid <= 1'b1;
				out_data.stratum <= 16'(ModWidth'(mrem));
				out_data.dim_out <= 6'(d_q);
				out_data.last    <= (d_q + 1'b1 == n_lim);
			end else if (out_acc) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		mx       = '0;
		mm       = MW'(p_q);
		unique case (state_q)
			oa_lhs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_data.op == oa_lhs_pkg::OP_SAMPLE) state_d = oa_lhs_pkg::ST_ADV;
			end
			oa_lhs_pkg::ST_ADV: begin
				ctl.start = 1'b1;
				mx = XW'(row_q) + XW'(step_q);
				mm = total_q;
				state_d = oa_lhs_pkg::ST_ADV_W;
			end
			oa_lhs_pkg::ST_ADV_W: begin
				mm = total_q;
				if (!mbusy) state_d = oa_lhs_pkg::ST_SPLIT;
			end
			oa_lhs_pkg::ST_SPLIT: begin
				ctl.start = 1'b1;
				ctl.quot  = 1'b1;
				mx = XW'(row_q);
				state_d = oa_lhs_pkg::ST_SPLIT_W;
			end
			oa_lhs_pkg::ST_SPLIT_W: if (!mbusy)
				state_d = (n_lim == '0) ? oa_lhs_pkg::ST_IDLE : oa_lhs_pkg::ST_RD;
			oa_lhs_pkg::ST_RD: state_d = oa_lhs_pkg::ST_M1;
			oa_lhs_pkg::ST_M1: state_d = oa_lhs_pkg::ST_R1;
			oa_lhs_pkg::ST_R1: begin
				ctl.start = 1'b1;
				mx = XW'(prod_q) + XW'(MW'(rb_q) * MW'(j_q));
				state_d = oa_lhs_pkg::ST_R1_W;
			end
			oa_lhs_pkg::ST_R1_W: if (!mbusy) state_d = oa_lhs_pkg::ST_M2;
			oa_lhs_pkg::ST_M2: state_d = oa_lhs_pkg::ST_R2;
			oa_lhs_pkg::ST_R2: begin
				ctl.start = 1'b1;
				mx = XW'(prod_q) + XW'(rd_q);
				state_d = oa_lhs_pkg::ST_R2_W;
			end
			oa_lhs_pkg::ST_R2_W: if (!mbusy) state_d = oa_lhs_pkg::ST_OUT;
			oa_lhs_pkg::ST_OUT: if (out_acc)
				state_d = (d_q + 1'b1 == n_lim) ? oa_lhs_pkg::ST_IDLE : oa_lhs_pkg::ST_RD;
			default: state_d = oa_lhs_pkg::ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != oa_lhs_pkg::ST_IDLE) |-> !in_ready)
		else $error("ready while busy");
	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == oa_lhs_pkg::ST_OUT))
		else $error("result outside output state");
	a_stratum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && p_q != '0) |-> (out_data.stratum < 16'(p_q)))
		else $error("stratum not below modulus");
`endif
endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the OA-LHS stratum generator: directed and random items checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int CycleLimit = 3000000;
	localparam int SettleCycles = 200;

	class strata_scoreboard;
		oa_lhs_pkg::out_item_t expected_strata[$];
		int unsigned mismatches;
		bit [15:0] prime;
		bit [31:0] step;
		bit [6:0] dims;
		bit [63:0] row;
		bit [63:0] row_total;
		bit [15:0] tab_a[oa_lhs_pkg::MaxDims];
		bit [15:0] tab_b[oa_lhs_pkg::MaxDims];
		bit [15:0] tab_mult[oa_lhs_pkg::MaxDims];
		bit [15:0] tab_add[oa_lhs_pkg::MaxDims];

		function new();
			prime = 11;
			step = 1;
			dims = 1;
			row = 0;
			row_total = 121;
			mismatches = 0;
		endfunction

		function void set_reg(logic [oa_lhs_pkg::CfgIdxW-1:0] idx, bit [31:0] val);
			case (idx)
				oa_lhs_pkg::REG_PRIME: begin
					prime = val[15:0];
					row_total = 64'(prime) * 64'(prime);
				end
				oa_lhs_pkg::REG_STEP: step = val;
				oa_lhs_pkg::REG_START: row = 64'(val);
				oa_lhs_pkg::REG_DIMS: dims = val[6:0];
				default: ;
			endcase
		endfunction

		function void note_item(oa_lhs_pkg::in_item_t it);
			bit [63:0] i, j, s;
			int n;
			oa_lhs_pkg::out_item_t r;
			if (it.op == oa_lhs_pkg::OP_LOAD) begin
				tab_a[it.dim_index] = it.coef_a;
				tab_b[it.dim_index] = it.coef_b;
				tab_mult[it.dim_index] = it.perm_mult;
				tab_add[it.dim_index] = it.perm_add;
				return;
			end
			row = (row_total == 0) ? 0 : (row + 64'(step)) % row_total;
			i = (prime == 0) ? 0 : row / prime;
			j = (prime == 0) ? 0 : row % prime;
			n = (dims > oa_lhs_pkg::MaxDims) ? oa_lhs_pkg::MaxDims : int'(dims);
			for (int d = 0; d < n; d++) begin
				s = 64'(tab_a[d]) * i + 64'(tab_b[d]) * j;
				s = (prime == 0) ? 0 : s % prime;
				s = 64'(tab_mult[d]) * s + 64'(tab_add[d]);
				s = (prime == 0) ? 0 : s % prime;
				r.stratum = s[15:0];
				r.dim_out = d[5:0];
				r.last = (d + 1 == n);
				expected_strata.insert(expected_strata.size(), r);
			end
		endfunction

		function void check_stratum(oa_lhs_pkg::out_item_t got);
			oa_lhs_pkg::out_item_t exp_r;
			if (expected_strata.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected transfer: stratum %0d dim %0d last %0b",
						got.stratum, got.dim_out, got.last);
				mismatches++;
				return;
			end
			exp_r = expected_strata.pop_front();
			if (got.stratum !== exp_r.stratum || got.dim_out !== exp_r.dim_out ||
					got.last !== exp_r.last) begin
				if (mismatches < 10)
					$display("mismatch: exp stratum %0d dim %0d last %0b, got %0d %0d %0b",
						exp_r.stratum, exp_r.dim_out, exp_r.last,
						got.stratum, got.dim_out, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	oa_lhs_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	oa_lhs_pkg::out_item_t out_data;
	logic cfg_we;
	logic [oa_lhs_pkg::CfgIdxW-1:0] cfg_index;
	logic [oa_lhs_pkg::CfgDataW-1:0] cfg_data;

	strata_scoreboard sb;
	bit idle_on;
	bit hold_req;
	bit [oa_lhs_pkg::MaxDims-1:0] written;

	oa_lhs_stratum_generator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall bursts plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_stratum(out_data);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 1500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic bit [15:0] pick16();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(oa_lhs_pkg::in_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		if (it.op == oa_lhs_pkg::OP_LOAD)
			written[it.dim_index] = 1'b1;
	endtask

	task automatic send_load(int d, bit [15:0] a, bit [15:0] b, bit [15:0] m, bit [15:0] ad);
		oa_lhs_pkg::in_item_t it;
		it.op = oa_lhs_pkg::OP_LOAD;
		it.dim_index = d[5:0];
		it.coef_a = a;
		it.coef_b = b;
		it.perm_mult = m;
		it.perm_add = ad;
		send_item(it);
	endtask

	task automatic send_sample();
		oa_lhs_pkg::in_item_t it;
		it.op = oa_lhs_pkg::OP_SAMPLE;
		it.dim_index = 6'($urandom);
		it.coef_a = 16'($urandom);
		it.coef_b = 16'($urandom);
		it.perm_mult = 16'($urandom);
		it.perm_add = 16'($urandom);
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_strata.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [oa_lhs_pkg::CfgIdxW-1:0] idx, bit [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(bit [15:0] p, bit [31:0] st, bit [31:0] start, bit [6:0] nd);
		wait_drained();
		write_reg(oa_lhs_pkg::REG_PRIME, 32'(p));
		write_reg(oa_lhs_pkg::REG_STEP, st);
		write_reg(oa_lhs_pkg::REG_START, start);
		write_reg(oa_lhs_pkg::REG_DIMS, 32'(nd));
		cfg_we <= 1'b0;
	endtask

	// samples only when every dimension they read has been loaded
	task automatic run_items(int count);
		int need;
		int gap;
		for (int k = 0; k < count; k++) begin
			need = (sb.dims > oa_lhs_pkg::MaxDims) ? oa_lhs_pkg::MaxDims : int'(sb.dims);
			gap = -1;
			for (int d = 0; d < need; d++)
				if (!written[d] && gap < 0) gap = d;
			if (gap >= 0)
				send_load(gap, pick16(), pick16(), pick16(), pick16());
			else if ($urandom_range(0, 3) == 0)
				send_load($urandom_range(0, oa_lhs_pkg::MaxDims - 1), pick16(), pick16(),
					pick16(), pick16());
			else
				send_sample();
		end
	endtask

	initial begin
		sb = new();
		written = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of coefficients at reset settings
		send_load(0, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
		send_sample();
		send_load(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample();
		send_sample();
		configure(16'd11, 32'd1, 32'd0, 7'd4);
		send_load(1, 16'd10, 16'd1, 16'd1, 16'd10);
		send_load(2, 16'd65520, 16'd0, 16'd65520, 16'd0);
		send_load(3, 16'd0, 16'd65520, 16'd1, 16'd65520);
		send_sample();
		send_sample();
		configure(16'd65521, 32'd4293001440, 32'd4293001440, 7'd2);
		send_sample();
		send_sample();
		// zero modulus
		configure(16'd0, 32'd5, 32'd7, 7'd2);
		send_sample();
		send_sample();
		// start row beyond row total, all-ones step
		configure(16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd1);
		send_sample();
		send_sample();
		// zero dimension count
		configure(16'd11, 32'd1, 32'd500, 7'd0);
		send_sample();
		send_sample();

		configure(16'd65521, 32'($urandom), 32'($urandom), 7'd3);
		run_items(4);
		configure(16'd13, 32'd7, 32'd3, 7'd64);
		run_items(64);
		// saturated dimension count
		configure(16'd17, 32'($urandom), 32'($urandom), 7'd127);
		send_sample();
		for (int r = 0; r < 3; r++) begin
			configure(16'($urandom_range(11, 65535)), 32'($urandom), 32'($urandom),
				7'($urandom_range(1, 8)));
			if (r == 1) begin
				@(negedge clk);
				hold_req = 1'b1;
			end
			run_items(12);
		end
		idle_on = 1'b0;
		configure(16'd65521, 32'd1, 32'd65520, 7'd5);
		run_items(8);

		wait_drained();
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/oa_lhs_pkg.sv
rtl/core/oa_lhs_modred.sv
rtl/core/oa_lhs_stratum_generator_core.sv
dv/testbench.sv
